### src/urta_pkg.sv
// Shared types and constants for the unsigned radix-to-ASCII converter.
package urta_pkg;

    localparam int NUM_MAX        = 64;
    localparam int NUM_WIDTH_DEF  = 64;
    localparam int MAX_DIGITS_DEF = 64;
    localparam int DIV_BITS       = 8;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [4:0] RADIX_MIN = 5'd2;
    localparam logic [4:0] RADIX_MAX = 5'd16;
    localparam logic [4:0] RADIX_OCT = 5'd8;
    localparam logic [4:0] RADIX_HEX = 5'd16;

    localparam logic [1:0] PRE_NONE = 2'd0;
    localparam logic [1:0] PRE_OCT  = 2'd1;
    localparam logic [1:0] PRE_HEX  = 2'd2;

    localparam logic [6:0] CH_ZERO   = 7'h30;
    localparam logic [6:0] CH_UP_A   = 7'h41;
    localparam logic [6:0] CH_LO_A   = 7'h61;
    localparam logic [6:0] CH_UP_X   = 7'h58;
    localparam logic [6:0] CH_LO_X   = 7'h78;

    typedef struct packed {
        logic [NUM_MAX-1:0] number;
        logic [4:0]         radix;
        logic               lower_case;
        logic               alt_form;
    } t_in;

    typedef struct packed {
        logic [6:0] character;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [NUM_MAX-1:0] number;
        logic [4:0]         radix;
        logic [2:0]         shift;
        logic               lower_case;
        logic [1:0]         pre_len;
    } t_job;

endpackage

### src/unsigned_radix_to_ascii.sv
// Top level of the unsigned radix-to-ASCII converter.
// Per digit: a shift and mask for bases 2, 4, 8 and 16, otherwise ceil(NUM_WIDTH/8) 8-bit
// restoring divide steps. Then the prefix characters go out, and each digit is read from the
// store and then emitted. A job is popped from the queue only while the back end is idle.
// Synchronous active-low reset empties the queue and clears the output valid; no clearing pass.
module unsigned_radix_to_ascii #(
    parameter int NUM_WIDTH  = urta_pkg::NUM_WIDTH_DEF,
    parameter int MAX_DIGITS = urta_pkg::MAX_DIGITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  urta_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output urta_pkg::t_out o_data
);

    logic           w_full;
    logic           w_push;
    urta_pkg::t_job w_push_job;
    logic           w_q_valid;
    logic           w_q_pop;
    urta_pkg::t_job w_q_job;

    urta_front #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_front (
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    urta_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_job   (w_q_job)
    );

    urta_back #(
        .NUM_WIDTH  (NUM_WIDTH),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_job   (w_q_job),
        .o_q_pop   (w_q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

endmodule

### src/urta_front.sv
// Front end: accepts input beats, drops bad bases, works out prefix and power-of-two shift.
module urta_front #(
    parameter int NUM_WIDTH = urta_pkg::NUM_WIDTH_DEF
) (
    input  logic          i_valid,
    output logic          o_ready,
    input  urta_pkg::t_in i_data,
    input  logic          i_full,
    output logic          o_push,
    output urta_pkg::t_job o_job
);

    localparam logic [urta_pkg::NUM_MAX-1:0] NUM_MASK =
        (urta_pkg::NUM_MAX'(1) << NUM_WIDTH) - urta_pkg::NUM_MAX'(1);

    logic                         w_base_ok;
    logic [urta_pkg::NUM_MAX-1:0] w_num;
    logic [2:0]                   w_shift;
    logic [1:0]                   w_pre;

    assign w_num     = i_data.number & NUM_MASK;
    assign w_base_ok = i_data.radix inside {[urta_pkg::RADIX_MIN:urta_pkg::RADIX_MAX]};

    always_comb begin
        case (i_data.radix)
            5'd2:    w_shift = 3'd1;
            5'd4:    w_shift = 3'd2;
            5'd8:    w_shift = 3'd3;
            5'd16:   w_shift = 3'd4;
            default: w_shift = 3'd0;
        endcase
    end

    always_comb begin
        w_pre = urta_pkg::PRE_NONE;
        if (i_data.alt_form) begin
            if (i_data.radix == urta_pkg::RADIX_OCT && w_num != '0) begin
                w_pre = urta_pkg::PRE_OCT;
            end else if (i_data.radix == urta_pkg::RADIX_HEX) begin
                w_pre = urta_pkg::PRE_HEX;
            end
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full && w_base_ok;

    always_comb begin
        o_job.number     = w_num;
        o_job.radix      = i_data.radix;
        o_job.shift      = w_shift;
        o_job.lower_case = i_data.lower_case;
        o_job.pre_len    = w_pre;
    end

endmodule

### src/urta_queue.sv
// Two-entry job queue between front and back.
module urta_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  urta_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output urta_pkg::t_job o_job
);

    urta_pkg::t_job r_mem [urta_pkg::QUEUE_DEPTH];
    logic           r_wr_ptr, n_wr_ptr;
    logic           r_rd_ptr, n_rd_ptr;
    logic [1:0]     r_count, n_count;

    assign o_full  = (r_count == 2'(urta_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(urta_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != 2'd0)
        else $error("pop from empty queue");

endmodule

### src/urta_back.sv
// Back end: digits by shift/mask or division, digit store and character output.
module urta_back #(
    parameter int NUM_WIDTH  = urta_pkg::NUM_WIDTH_DEF,
    parameter int MAX_DIGITS = urta_pkg::MAX_DIGITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  urta_pkg::t_job i_q_job,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output urta_pkg::t_out o_data
);

    localparam int DIV_STEPS = (NUM_WIDTH + urta_pkg::DIV_BITS - 1) / urta_pkg::DIV_BITS;
    localparam int QW        = DIV_STEPS * urta_pkg::DIV_BITS;
    localparam int SW        = $clog2(DIV_STEPS + 1);
    localparam int CW        = $clog2(MAX_DIGITS + 1);
    localparam int AW        = $clog2(MAX_DIGITS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_PRE  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    function automatic logic [6:0] digit_char(input logic [3:0] d, input logic lc);
        logic [6:0] base_ch;
        base_ch = lc ? urta_pkg::CH_LO_A : urta_pkg::CH_UP_A;
        if (d < 4'd10) begin
            return urta_pkg::CH_ZERO + {3'b000, d};
        end
        return base_ch + {3'b000, d} - 7'd10;
    endfunction

    logic [3:0]       r_store [MAX_DIGITS];
    logic [2:0]       r_state, n_state;
    logic [QW-1:0]    r_quot, n_quot;
    logic [3:0]       r_rem, n_rem;
    logic [SW-1:0]    r_step, n_step;
    logic [4:0]       r_base, n_base;
    logic [2:0]       r_shift, n_shift;
    logic             r_lc, n_lc;
    logic [1:0]       r_pre, n_pre;
    logic             r_hex, n_hex;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [3:0]       r_rdata;
    logic             r_out_valid, n_out_valid;
    urta_pkg::t_out   r_out, n_out;

    logic [urta_pkg::DIV_BITS-1:0] w_qbits;
    logic [3:0]       w_div_rem;
    logic [3:0]       w_p2_dig;
    logic [QW-1:0]    w_p2_quot;
    logic             w_out_free;
    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    logic [3:0]       w_wr_data;
    logic             w_rd_en;
    logic [CW-1:0]    w_cnt_m1;

    // eight restoring-division bit steps per cycle, MSB first
    always_comb begin
        logic [4:0] t;
        logic [3:0] rem;
        rem     = r_rem;
        w_qbits = '0;
        for (int i = 0; i < urta_pkg::DIV_BITS; i++) begin
            t = {rem, r_quot[QW-1-i]};
            if (t >= r_base) begin
                t = t - r_base;
                w_qbits[urta_pkg::DIV_BITS-1-i] = 1'b1;
            end
            rem = t[3:0];
        end
        w_div_rem = rem;
    end

    assign w_p2_dig   = r_quot[3:0] & (r_base[3:0] - 4'd1);
    assign w_p2_quot  = r_quot >> r_shift;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_cnt_m1   = r_cnt - CW'(1);

    always_comb begin
        logic           digit_done;
        logic [3:0]     digit;
        logic [QW-1:0]  quot_next;
        n_state     = r_state;
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_step      = r_step;
        n_base      = r_base;
        n_shift     = r_shift;
        n_lc        = r_lc;
        n_pre       = r_pre;
        n_hex       = r_hex;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_cnt[AW-1:0];
        w_wr_data   = '0;
        w_rd_en     = 1'b0;
        digit_done  = 1'b0;
        digit       = '0;
        quot_next   = r_quot;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_quot  = QW'(i_q_job.number[NUM_WIDTH-1:0]);
                    n_base  = i_q_job.radix;
                    n_shift = i_q_job.shift;
                    n_lc    = i_q_job.lower_case;
                    n_pre   = i_q_job.pre_len;
                    n_hex   = (i_q_job.pre_len == urta_pkg::PRE_HEX);
                    n_cnt   = '0;
                    n_step  = '0;
                    n_rem   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_shift != 3'd0) begin
                    digit_done = 1'b1;
                    digit      = w_p2_dig;
                    quot_next  = w_p2_quot;
                end else begin
                    quot_next = (r_quot << urta_pkg::DIV_BITS) | QW'(w_qbits);
                    n_quot    = quot_next;
                    n_rem     = w_div_rem;
                    n_step    = r_step + SW'(1);
                    if (r_step == SW'(DIV_STEPS - 1)) begin
                        digit_done = 1'b1;
                        digit      = w_div_rem;
                    end
                end
                if (digit_done) begin
                    n_quot = quot_next;
                    n_rem  = '0;
                    n_step = '0;
                    if (r_cnt < CW'(MAX_DIGITS)) begin
                        w_wr_en   = 1'b1;
                        w_wr_data = digit;
                        n_cnt     = r_cnt + CW'(1);
                    end
                    if (quot_next == '0) begin
                        n_state = S_PRE;
                    end
                end
            end
            S_PRE: begin
                if (r_pre == urta_pkg::PRE_NONE) begin
                    n_state = S_RD;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out.last  = 1'b0;
                    if (r_hex && r_pre == 2'd1) begin
                        n_out.character = r_lc ? urta_pkg::CH_LO_X : urta_pkg::CH_UP_X;
                    end else begin
                        n_out.character = urta_pkg::CH_ZERO;
                    end
                    n_pre = r_pre - 2'd1;
                end
            end
            S_RD: begin
                w_rd_en = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.character = digit_char(r_rdata, r_lc);
                    n_out.last      = (r_cnt == CW'(1));
                    n_cnt           = w_cnt_m1;
                    n_state         = (r_cnt == CW'(1)) ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_pre       <= urta_pkg::PRE_NONE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_pre       <= n_pre;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot  <= n_quot;
        r_rem   <= n_rem;
        r_base  <= n_base;
        r_shift <= n_shift;
        r_lc    <= n_lc;
        r_hex   <= n_hex;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_store[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_store[w_cnt_m1[AW-1:0]];
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_DIGITS))
        else $error("digit count beyond store depth");

    a_emit_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_EMIT) |-> r_cnt != '0)
        else $error("digit read with empty store");

    a_div_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> (r_base >= urta_pkg::RADIX_MIN && r_base <= urta_pkg::RADIX_MAX))
        else $error("division with bad base");

endmodule
